// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the interferometer mesh block.
// Depends on nothing; a file that asserts includes it and provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MZI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Assertion failed.");
`define MZI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed.");
`else
`define MZI_ASSERT_IMPL(lbl, ante, cons)
`define MZI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/mzi_pkg.sv =====
// Constants, codes and the CORDIC arctangent table of the interferometer mesh block.
// Depends on nothing.
`timescale 1ns / 1ps
package mzi_pkg;
  localparam int MAX_MODES    = 16;
  localparam int MAX_STAGES   = 128;
  localparam int AMP_BITS     = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int MODE_W       = 4;
  localparam int SLOT_W       = 7;
  localparam int STEP_W       = 4;
  localparam int CW           = 34;
  localparam int COEF_W       = 18;
  localparam int PROD_W       = 36;
  localparam int ACC_W        = 38;
  localparam int STAGE_W      = 2 * MODE_W + 2 * ANGLE_BITS;

  localparam logic [1:0] REQ_STAGE     = 2'd0;
  localparam logic [1:0] REQ_AMP       = 2'd1;
  localparam logic [1:0] REQ_PROPAGATE = 2'd2;

  localparam logic [1:0] CFG_MODE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_STAGE_COUNT = 2'd1;

  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      default: v = 32'h0000517D;
    endcase
    return v;
  endfunction
endpackage

// ===== hdl/mzi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module mzi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/mzi_cordic.sv =====
// Iterative CORDIC that gives cosine and sine in Q16 for an angle in binary turns.
// Depends on mzi_pkg.
`timescale 1ns / 1ps
module mzi_cordic (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [mzi_pkg::ANGLE_BITS-1:0]         angle,
  output logic                                   done,
  output logic signed [mzi_pkg::COEF_W-1:0]      cos_q,
  output logic signed [mzi_pkg::COEF_W-1:0]      sin_q
);
  import mzi_pkg::*;

  logic signed [CW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [1:0]           q_r, q_nxt;
  logic [STEP_W-1:0]    i_r, i_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0]          a32, zr;
  logic [1:0]           q0;
  logic signed [CW-1:0] shx, shy, at, cx, cy, rx, ry;

  always_comb begin
    a32 = 32'({angle, {(32 - ANGLE_BITS){1'b0}}});
    q0  = 2'((a32 + 32'h2000_0000) >> 30);
    zr  = a32 - {q0, 30'b0};
    shx = x_r >>> i_r;
    shy = y_r >>> i_r;
    at  = CW'(signed'({1'b0, atan_turns(i_r)}));
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; q_nxt = q_r; i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt = CORDIC_X0;
      y_nxt = '0;
      z_nxt = CW'(signed'(zr));
      q_nxt = q0;
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - shy; y_nxt = y_r + shx; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + shy; y_nxt = y_r - shx; z_nxt = z_r + at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    case (q_r)
      2'd0:    begin cx = x_r;  cy = y_r;  end
      2'd1:    begin cx = -y_r; cy = x_r;  end
      2'd2:    begin cx = -x_r; cy = -y_r; end
      default: begin cx = y_r;  cy = -x_r; end
    endcase
    rx = (cx + CW'(8192)) >>> 14;
    ry = (cy + CW'(8192)) >>> 14;
  end

  assign cos_q = rx[COEF_W-1:0];
  assign sin_q = ry[COEF_W-1:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    q_r <= q_nxt;
    i_r <= i_nxt;
  end
endmodule

// ===== hdl/mzi_mesh_forward_propagation.sv =====
// Top level of the interferometer mesh forward propagation block.
// Depends on mzi_pkg, mzi_ram, mzi_cordic and assert_macros.svh.
//
// Stage and amplitude writes are taken while the block is idle. A propagate
// transfer holds the input stalled until its last mode result is taken. It copies
// the sixteen input modes and makes one final table check; per applied stage it
// does a table read and port check, two 16-step CORDIC passes on the one CORDIC
// unit, sixteen products on the one 18x18 multiplier and two work memory writes;
// per skipped stage it does a table read and port check; then it emits each
// mode in turn.
`timescale 1ns / 1ps
module mzi_mesh_forward_propagation (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_req_type,
  input  logic [mzi_pkg::SLOT_W-1:0]            in_slot,
  input  logic [mzi_pkg::MODE_W-1:0]            in_port_a,
  input  logic [mzi_pkg::MODE_W-1:0]            in_port_b,
  input  logic [mzi_pkg::ANGLE_BITS-1:0]        in_theta_in,
  input  logic [mzi_pkg::ANGLE_BITS-1:0]        in_phi_in,
  input  logic signed [mzi_pkg::AMP_BITS-1:0]   in_re_in,
  input  logic signed [mzi_pkg::AMP_BITS-1:0]   in_im_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mzi_pkg::MODE_W-1:0]            out_mode_out,
  output logic signed [mzi_pkg::AMP_BITS-1:0]   out_re_out,
  output logic signed [mzi_pkg::AMP_BITS-1:0]   out_im_out,
  output logic                                  out_last,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [7:0]                            cfg_wdata
);
  import mzi_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001, S_COPY  = 18'h00002, S_FETCH = 18'h00004,
    S_CHECK = 18'h00008, S_CTH   = 18'h00010, S_CPH   = 18'h00020,
    S_CMUL  = 18'h00040, S_CRND  = 18'h00080, S_RDA   = 18'h00100,
    S_RDB   = 18'h00200, S_RDW   = 18'h00400, S_MUL   = 18'h00800,
    S_ACC   = 18'h01000, S_WRA   = 18'h02000, S_WRB   = 18'h04000,
    S_ERD   = 18'h08000, S_ELD   = 18'h10000, S_EWAIT = 18'h20000
  } state_t;

  typedef logic signed [AMP_BITS-1:0] amp_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  state_t state_r, state_nxt;
  logic [4:0] mode_count_r, mode_count_nxt, mc_r, mc_nxt;
  logic [7:0] stage_count_r, stage_count_nxt, sc_r, sc_nxt, k_r, k_nxt;
  logic [MODE_W-1:0] m_r, m_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  logic [1:0] n_r, n_nxt, c_r, c_nxt, t_r, t_nxt;
  logic [ANGLE_BITS-1:0] phi_r, phi_nxt;
  coef_t ct_r, ct_nxt, st_r, st_nxt, cph_r, cph_nxt, sph_r, sph_nxt;
  coef_t are_r, are_nxt, aim_r, aim_nxt, bre_r, bre_nxt, bim_r, bim_nxt;
  amp_t ar_r, ar_nxt, ai_r, ai_nxt, br_r, br_nxt, bi_r, bi_nxt;
  amp_t oar_r, oar_nxt, oai_r, oai_nxt, obr_r, obr_nxt, obi_r, obi_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_sum, acc_term, acc_rnd;
  amp_t in_re_r [MAX_MODES];
  amp_t in_im_r [MAX_MODES];
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [MODE_W-1:0] out_mode_r, out_mode_nxt;
  amp_t out_re_r, out_re_nxt, out_im_r, out_im_nxt, sat_v;

  logic in_acc;
  logic st_we;
  logic [STAGE_W-1:0] st_wdata, st_rdata;
  logic wk_we;
  logic [MODE_W-1:0] wk_waddr, wk_raddr;
  logic [2*AMP_BITS-1:0] wk_wdata, wk_rdata;
  logic cd_start, cd_done;
  logic [ANGLE_BITS-1:0] cd_angle;
  coef_t cd_cos, cd_sin, mul_a, mul_b;
  logic signed [PROD_W-1:0] c_rnd;
  logic neg;
  logic [MODE_W-1:0] sd_pa, sd_pb;
  logic [ANGLE_BITS-1:0] sd_theta, sd_phi;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign {sd_pa, sd_pb, sd_theta, sd_phi} = st_rdata;

  assign st_we    = in_acc && (in_req_type == REQ_STAGE) && (32'(in_slot) < MAX_STAGES);
  assign st_wdata = {in_port_a, in_port_b, in_theta_in, in_phi_in};

  mzi_ram #(.WIDTH(STAGE_W), .DEPTH(MAX_STAGES)) u_stage_ram (
    .clk(clk), .we(st_we), .waddr(in_slot), .wdata(st_wdata),
    .raddr(k_r[SLOT_W-1:0]), .rdata(st_rdata)
  );

  mzi_ram #(.WIDTH(2 * AMP_BITS), .DEPTH(MAX_MODES)) u_work_ram (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata)
  );

  assign cd_start = (state_r == S_CHECK && !(5'(sd_pa) >= mc_r || 5'(sd_pb) >= mc_r))
                 || (state_r == S_CTH && cd_done);
  assign cd_angle = (state_r == S_CHECK) ? sd_theta : phi_r;

  mzi_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cd_start), .angle(cd_angle),
    .done(cd_done), .cos_q(cd_cos), .sin_q(cd_sin)
  );

  always_comb begin
    wk_we = 1'b0;
    wk_waddr = m_r;
    wk_wdata = {in_re_r[m_r], in_im_r[m_r]};
    wk_raddr = pa_r;
    case (state_r)
      S_COPY: wk_we = 1'b1;
      S_WRA: begin
        wk_we = 1'b1; wk_waddr = pa_r; wk_wdata = {oar_r, oai_r};
      end
      S_WRB: begin
        wk_we = 1'b1; wk_waddr = pb_r; wk_wdata = {obr_r, obi_r};
      end
      S_RDB: wk_raddr = pb_r;
      S_ERD: wk_raddr = m_r;
      default: wk_raddr = pa_r;
    endcase
  end

  always_comb begin
    neg = 1'b0;
    mul_a = cph_r;
    mul_b = ct_r;
    if (state_r == S_CMUL) begin
      case (n_r)
        2'd0:    begin mul_a = cph_r; mul_b = ct_r; end
        2'd1:    begin mul_a = sph_r; mul_b = ct_r; end
        2'd2:    begin mul_a = cph_r; mul_b = st_r; end
        default: begin mul_a = sph_r; mul_b = st_r; end
      endcase
    end else begin
      case ({c_r, t_r})
        4'h0:    begin mul_a = are_r; mul_b = COEF_W'(ar_r); end
        4'h1:    begin mul_a = aim_r; mul_b = COEF_W'(ai_r); neg = 1'b1; end
        4'h2:    begin mul_a = st_r;  mul_b = COEF_W'(br_r); neg = 1'b1; end
        4'h4:    begin mul_a = are_r; mul_b = COEF_W'(ai_r); end
        4'h5:    begin mul_a = aim_r; mul_b = COEF_W'(ar_r); end
        4'h6:    begin mul_a = st_r;  mul_b = COEF_W'(bi_r); neg = 1'b1; end
        4'h8:    begin mul_a = bre_r; mul_b = COEF_W'(ar_r); end
        4'h9:    begin mul_a = bim_r; mul_b = COEF_W'(ai_r); neg = 1'b1; end
        4'hA:    begin mul_a = ct_r;  mul_b = COEF_W'(br_r); end
        4'hC:    begin mul_a = bre_r; mul_b = COEF_W'(ai_r); end
        4'hD:    begin mul_a = bim_r; mul_b = COEF_W'(ar_r); end
        default: begin mul_a = ct_r;  mul_b = COEF_W'(bi_r); end
      endcase
    end
    c_rnd    = (prod_r + PROD_W'(32768)) >>> 16;
    acc_term = neg ? -ACC_W'(prod_r) : ACC_W'(prod_r);
    acc_sum  = ((t_r == 2'd0) ? ACC_W'(0) : acc_r) + acc_term;
    acc_rnd  = (acc_sum + ACC_W'(32768)) >>> 16;
    if (acc_rnd > ACC_W'(32767)) begin
      sat_v = AMP_BITS'(32767);
    end else if (acc_rnd < -ACC_W'(32768)) begin
      sat_v = AMP_BITS'(-32768);
    end else begin
      sat_v = acc_rnd[AMP_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_count_nxt = mode_count_r; stage_count_nxt = stage_count_r;
    mc_nxt = mc_r; sc_nxt = sc_r; k_nxt = k_r; m_nxt = m_r;
    pa_nxt = pa_r; pb_nxt = pb_r; n_nxt = n_r; c_nxt = c_r; t_nxt = t_r;
    phi_nxt = phi_r;
    ct_nxt = ct_r; st_nxt = st_r; cph_nxt = cph_r; sph_nxt = sph_r;
    are_nxt = are_r; aim_nxt = aim_r; bre_nxt = bre_r; bim_nxt = bim_r;
    ar_nxt = ar_r; ai_nxt = ai_r; br_nxt = br_r; bi_nxt = bi_r;
    oar_nxt = oar_r; oai_nxt = oai_r; obr_nxt = obr_r; obi_nxt = obi_r;
    prod_nxt = prod_r; acc_nxt = acc_r;
    out_valid_nxt = out_valid_r; out_last_nxt = out_last_r;
    out_mode_nxt = out_mode_r; out_re_nxt = out_re_r; out_im_nxt = out_im_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE_COUNT:  mode_count_nxt = cfg_wdata[4:0];
        CFG_STAGE_COUNT: stage_count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_req_type == REQ_PROPAGATE) begin
          if (mode_count_r < 5'd2) begin
            mc_nxt = 5'd2;
          end else if (32'(mode_count_r) > MAX_MODES) begin
            mc_nxt = 5'(MAX_MODES);
          end else begin
            mc_nxt = mode_count_r;
          end
          sc_nxt = (32'(stage_count_r) > MAX_STAGES) ? 8'(MAX_STAGES) : stage_count_r;
          m_nxt = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        m_nxt = m_r + 1'b1;
        if (m_r == MODE_W'(MAX_MODES - 1)) begin
          k_nxt = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (k_r == sc_r) begin
          m_nxt = '0;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        pa_nxt = sd_pa;
        pb_nxt = sd_pb;
        phi_nxt = sd_phi;
        if (5'(sd_pa) >= mc_r || 5'(sd_pb) >= mc_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_CTH;
        end
      end
      S_CTH: begin
        if (cd_done) begin
          ct_nxt = cd_cos;
          st_nxt = cd_sin;
          state_nxt = S_CPH;
        end
      end
      S_CPH: begin
        if (cd_done) begin
          cph_nxt = cd_cos;
          sph_nxt = cd_sin;
          n_nxt = '0;
          state_nxt = S_CMUL;
        end
      end
      S_CMUL: begin
        prod_nxt = PROD_W'(mul_a * mul_b);
        state_nxt = S_CRND;
      end
      S_CRND: begin
        case (n_r)
          2'd0:    are_nxt = c_rnd[COEF_W-1:0];
          2'd1:    aim_nxt = c_rnd[COEF_W-1:0];
          2'd2:    bre_nxt = c_rnd[COEF_W-1:0];
          default: bim_nxt = c_rnd[COEF_W-1:0];
        endcase
        n_nxt = n_r + 1'b1;
        state_nxt = (n_r == 2'd3) ? S_RDA : S_CMUL;
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        ar_nxt = wk_rdata[2*AMP_BITS-1:AMP_BITS];
        ai_nxt = wk_rdata[AMP_BITS-1:0];
        state_nxt = S_RDW;
      end
      S_RDW: begin
        br_nxt = wk_rdata[2*AMP_BITS-1:AMP_BITS];
        bi_nxt = wk_rdata[AMP_BITS-1:0];
        c_nxt = '0;
        t_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = PROD_W'(mul_a * mul_b);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_sum;
        state_nxt = S_MUL;
        if (t_r == 2'd2) begin
          case (c_r)
            2'd0:    oar_nxt = sat_v;
            2'd1:    oai_nxt = sat_v;
            2'd2:    obr_nxt = sat_v;
            default: obi_nxt = sat_v;
          endcase
          t_nxt = '0;
          c_nxt = c_r + 1'b1;
          if (c_r == 2'd3) begin
            state_nxt = S_WRA;
          end
        end else begin
          t_nxt = t_r + 1'b1;
        end
      end
      S_WRA: state_nxt = S_WRB;
      S_WRB: begin
        k_nxt = k_r + 1'b1;
        state_nxt = S_FETCH;
      end
      S_ERD: state_nxt = S_ELD;
      S_ELD: begin
        out_valid_nxt = 1'b1;
        out_mode_nxt = m_r;
        out_re_nxt = wk_rdata[2*AMP_BITS-1:AMP_BITS];
        out_im_nxt = wk_rdata[AMP_BITS-1:0];
        out_last_nxt = (5'(m_r) == mc_r - 5'd1);
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          m_nxt = m_r + 1'b1;
          state_nxt = out_last_r ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_count_r <= 5'd2;
      stage_count_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_MODES; i++) begin
        in_re_r[i] <= '0;
        in_im_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      mode_count_r <= mode_count_nxt;
      stage_count_r <= stage_count_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc && in_req_type == REQ_AMP && 32'(in_slot) < MAX_MODES) begin
        in_re_r[in_slot[MODE_W-1:0]] <= in_re_in;
        in_im_r[in_slot[MODE_W-1:0]] <= in_im_in;
      end
    end
    mc_r <= mc_nxt; sc_r <= sc_nxt; k_r <= k_nxt; m_r <= m_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt; n_r <= n_nxt; c_r <= c_nxt; t_r <= t_nxt;
    phi_r <= phi_nxt;
    ct_r <= ct_nxt; st_r <= st_nxt; cph_r <= cph_nxt; sph_r <= sph_nxt;
    are_r <= are_nxt; aim_r <= aim_nxt; bre_r <= bre_nxt; bim_r <= bim_nxt;
    ar_r <= ar_nxt; ai_r <= ai_nxt; br_r <= br_nxt; bi_r <= bi_nxt;
    oar_r <= oar_nxt; oai_r <= oai_nxt; obr_r <= obr_nxt; obi_r <= obi_nxt;
    prod_r <= prod_nxt; acc_r <= acc_nxt;
    out_last_r <= out_last_nxt; out_mode_r <= out_mode_nxt;
    out_re_r <= out_re_nxt; out_im_r <= out_im_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_mode_out = out_mode_r;
  assign out_re_out   = out_re_r;
  assign out_im_out   = out_im_r;
  assign out_last     = out_last_r;

  `MZI_ASSERT_IMPL(a_out_in_wait, out_valid_r, state_r == S_EWAIT)
  `MZI_ASSERT_IMPL(a_cordic_done_expected, cd_done, state_r == S_CTH || state_r == S_CPH)
  `MZI_ASSERT_IMPL(a_last_mode, out_valid_r && out_last_r, 5'(out_mode_r) == mc_r - 5'd1)
  `MZI_ASSERT_NEXT(a_last_ends_run, out_valid_r && out_last_r && !out_stall,
                   state_r == S_IDLE)
endmodule

// ===== bench/mzi_mesh_amplitude_checker.sv =====
// Watches the request, result and register ports of the interferometer mesh,
// predicts every emitted mode amplitude and compares it with what arrives.
// Depends on mzi_pkg for request and register codes.
`timescale 1ns / 1ps
module mzi_mesh_amplitude_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_slot,
  input  logic [3:0]  in_port_a,
  input  logic [3:0]  in_port_b,
  input  logic [15:0] in_theta_in,
  input  logic [15:0] in_phi_in,
  input  logic signed [15:0] in_re_in,
  input  logic signed [15:0] in_im_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_mode_out,
  input  logic signed [15:0] out_re_out,
  input  logic signed [15:0] out_im_out,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import mzi_pkg::*;

  typedef struct {
    logic [3:0]         mode;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } mode_amp_t;

  localparam longint ATAN_STEP [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  mode_amp_t  amp_q[$];
  logic [4:0] mode_reg;
  logic [7:0] stage_reg;
  logic [3:0] tbl_pa [128];
  logic [3:0] tbl_pb [128];
  logic [15:0] tbl_theta [128];
  logic [15:0] tbl_phi [128];
  longint src_re [16];
  longint src_im [16];

  function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a32, q, zu;
    longint x, y, z, nx, cx, cy;
    a32 = {ang, 16'h0000};
    q = ((a32 + 32'h20000000) >> 30) & 32'd3;
    zu = a32 - (q << 30);
    z = $signed(zu);
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_STEP[i];
      end
      x = nx;
    end
    case (q[1:0])
      2'd0: begin cx = x; cy = y; end
      2'd1: begin cx = -y; cy = x; end
      2'd2: begin cx = -x; cy = -y; end
      default: begin cx = y; cy = -x; end
    endcase
    c = (cx + 8192) >>> 14;
    s = (cy + 8192) >>> 14;
  endfunction

  function automatic longint round_q16(input longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint clip_amp(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic propagate_modes();
    int mc, sc, pa, pb;
    longint wr [16];
    longint wi [16];
    longint ct, st, cph, sph, are, aim, bre, bim, ar, ai, br, bi, oar, oai;
    mode_amp_t e;
    mc = (mode_reg < 2) ? 2 : (mode_reg > 16) ? 16 : mode_reg;
    sc = (stage_reg > 128) ? 128 : stage_reg;
    for (int m = 0; m < 16; m++) begin
      wr[m] = src_re[m];
      wi[m] = src_im[m];
    end
    for (int k = 0; k < sc; k++) begin
      pa = tbl_pa[k];
      pb = tbl_pb[k];
      if (pa >= mc || pb >= mc) continue;
      sin_cos(tbl_theta[k], ct, st);
      sin_cos(tbl_phi[k], cph, sph);
      are = round_q16(cph * ct);
      aim = round_q16(sph * ct);
      bre = round_q16(cph * st);
      bim = round_q16(sph * st);
      ar = wr[pa]; ai = wi[pa];
      br = wr[pb]; bi = wi[pb];
      oar = clip_amp(round_q16(are * ar - aim * ai - st * br));
      oai = clip_amp(round_q16(are * ai + aim * ar - st * bi));
      wr[pb] = clip_amp(round_q16(bre * ar - bim * ai + ct * br));
      wi[pb] = clip_amp(round_q16(bre * ai + bim * ar + ct * bi));
      wr[pa] = oar;
      wi[pa] = oai;
      if (pa == pb) begin
        wr[pb] = clip_amp(round_q16(bre * ar - bim * ai + ct * br));
        wi[pb] = clip_amp(round_q16(bre * ai + bim * ar + ct * bi));
      end
    end
    for (int m = 0; m < mc; m++) begin
      e.mode = m[3:0];
      e.re = wr[m][15:0];
      e.im = wi[m][15:0];
      e.last = (m == mc - 1);
      amp_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    mode_amp_t e;
    if (!rst_n) begin
      mode_reg <= 5'd2;
      stage_reg <= 8'd0;
      for (int m = 0; m < 16; m++) begin
        src_re[m] = 0;
        src_im[m] = 0;
      end
      for (int k = 0; k < 128; k++) begin
        tbl_pa[k] = '0; tbl_pb[k] = '0; tbl_theta[k] = '0; tbl_phi[k] = '0;
      end
      amp_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MODE_COUNT) mode_reg <= cfg_wdata[4:0];
        else if (cfg_index == CFG_STAGE_COUNT) stage_reg <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        case (in_req_type)
          REQ_STAGE: begin
            tbl_pa[in_slot] = in_port_a;
            tbl_pb[in_slot] = in_port_b;
            tbl_theta[in_slot] = in_theta_in;
            tbl_phi[in_slot] = in_phi_in;
          end
          REQ_AMP: begin
            if (in_slot < 16) begin
              src_re[in_slot] = in_re_in;
              src_im[in_slot] = in_im_in;
            end
          end
          REQ_PROPAGATE: propagate_modes();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (amp_q.size() == 0) begin
          $error("Result transfer with no amplitude expected: mode %0d", out_mode_out);
          fail_count <= fail_count + 1;
        end else begin
          e = amp_q.pop_front();
          if (out_mode_out !== e.mode || out_re_out !== e.re || out_im_out !== e.im ||
              out_last !== e.last) begin
            fail_count <= fail_count + 1;
            if (out_mode_out !== e.mode)
              $error("mode_out: expected %0d, actual %0d", e.mode, out_mode_out);
            if (out_re_out !== e.re)
              $error("re_out: expected %0d, actual %0d", e.re, out_re_out);
            if (out_im_out !== e.im)
              $error("im_out: expected %0d, actual %0d", e.im, out_im_out);
            if (out_last !== e.last)
              $error("last: expected %0d, actual %0d", e.last, out_last);
          end
        end
      end
      pending <= amp_q.size();
    end
  end
endmodule

// ===== bench/mzi_mesh_forward_propagation_test.sv =====
// Top of the interferometer mesh testbench: clock, reset, register settings and
// request traffic, with the amplitude checker beside the block giving the verdict.
// Depends on mzi_pkg, mzi_mesh_forward_propagation and mzi_mesh_amplitude_checker.
`timescale 1ns / 1ps
module mzi_mesh_forward_propagation_test;
  import mzi_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int IDLE_LIMIT = 120000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [6:0] in_slot = '0;
  logic [3:0] in_port_a = '0;
  logic [3:0] in_port_b = '0;
  logic [15:0] in_theta_in = '0;
  logic [15:0] in_phi_in = '0;
  logic signed [15:0] in_re_in = '0;
  logic signed [15:0] in_im_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_mode_out;
  logic signed [15:0] out_re_out;
  logic signed [15:0] out_im_out;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  int fail_count;
  int pending;
  int tx_idle = 0;
  int rx_idle = 0;
  int idle_cycles = 0;
  int eff_modes = 2;
  int eff_stages = 0;
  bit stage_written [128];

  always #1 clk = ~clk;

  mzi_mesh_forward_propagation u_dut (.*);
  mzi_mesh_amplitude_checker u_amp_check (.*);

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < rx_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [6:0] slot,
                          input logic [3:0] pa, input logic [3:0] pb,
                          input logic [15:0] th, input logic [15:0] ph,
                          input logic [15:0] re, input logic [15:0] im);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_slot <= slot;
    in_port_a <= pa;
    in_port_b <= pb;
    in_theta_in <= th;
    in_phi_in <= ph;
    in_re_in <= re;
    in_im_in <= im;
    if (req == REQ_STAGE) stage_written[slot] = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MODE_COUNT)
      eff_modes = (val[4:0] < 2) ? 2 : (val[4:0] > 16) ? 16 : val[4:0];
    else if (idx == CFG_STAGE_COUNT)
      eff_stages = (val > 128) ? 128 : val;
  endtask

  function automatic int first_unwritten();
    for (int k = 0; k < eff_stages; k++)
      if (!stage_written[k]) return k;
    return -1;
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] corners [6] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
    if ($urandom_range(9) == 0) return corners[$urandom_range(5)];
    return $urandom_range(16'hFFFF);
  endfunction

  function automatic logic [15:0] pick_amp();
    if ($urandom_range(99) < 15) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return $urandom_range(16'hFFFF);
  endfunction

  function automatic logic [3:0] pick_port();
    if ($urandom_range(99) < 85) return $urandom_range(eff_modes - 1);
    return $urandom_range(15);
  endfunction

  task automatic random_phase(input int count);
    int done_items, r, hole;
    done_items = 0;
    while (done_items < count) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_req(REQ_UNKNOWN, $urandom_range(127), $urandom_range(15), $urandom_range(15),
                 pick_angle(), pick_angle(), pick_amp(), pick_amp());
      end else if (r < 18) begin
        hole = first_unwritten();
        if (hole >= 0) begin
          send_req(REQ_STAGE, hole, pick_port(), pick_port(), pick_angle(), pick_angle(),
                   pick_amp(), pick_amp());
          continue;
        end
        send_req(REQ_PROPAGATE, $urandom_range(127), $urandom_range(15), $urandom_range(15),
                 pick_angle(), pick_angle(), pick_amp(), pick_amp());
      end else if (r < 55) begin
        send_req(REQ_STAGE, (eff_stages > 0 && $urandom_range(9) < 7) ?
                 $urandom_range(eff_stages - 1) : $urandom_range(127),
                 pick_port(), pick_port(), pick_angle(), pick_angle(), pick_amp(), pick_amp());
      end else begin
        send_req(REQ_AMP, ($urandom_range(9) != 0) ? $urandom_range(15) : $urandom_range(16, 127),
                 $urandom_range(15), $urandom_range(15), pick_angle(), pick_angle(),
                 pick_amp(), pick_amp());
      end
      done_items++;
    end
  endtask

  initial begin
    logic [4:0] mode_set [9] = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd8, 5'd1, 5'd5, 5'd17, 5'd12};
    logic [7:0] stage_set [9] = '{8'd5, 8'd255, 8'd10, 8'd2, 8'd128, 8'd0, 8'd20, 8'd7, 8'd40};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(REQ_PROPAGATE, 7'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_req(REQ_AMP, 7'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h7FFF, 16'h8000);
    send_req(REQ_AMP, 7'd1, 4'd0, 4'd0, 16'h0, 16'h0, 16'h8000, 16'h7FFF);
    send_req(REQ_AMP, 7'd2, 4'd0, 4'd0, 16'h0, 16'h0, 16'h4000, 16'hC000);
    send_req(REQ_AMP, 7'd3, 4'd0, 4'd0, 16'h0, 16'h0, 16'hFFFF, 16'h0001);
    send_req(REQ_AMP, 7'd15, 4'd0, 4'd0, 16'h0, 16'h0, 16'h1234, 16'hEDCB);
    send_req(REQ_AMP, 7'd127, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'h5555);
    send_req(REQ_UNKNOWN, 7'd127, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_PROPAGATE, 7'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    drain();
    write_reg(CFG_MODE_COUNT, 8'd4);
    write_reg(CFG_STAGE_COUNT, 8'd5);
    write_reg(CFG_SPARE_A, 8'hFF);
    write_reg(CFG_SPARE_B, 8'hFF);
    send_req(REQ_STAGE, 7'd0, 4'd0, 4'd1, 16'h0000, 16'h0000, 16'h0, 16'h0);
    send_req(REQ_STAGE, 7'd1, 4'd1, 4'd1, 16'h2000, 16'hFFFF, 16'h0, 16'h0);
    send_req(REQ_STAGE, 7'd2, 4'd15, 4'd0, 16'h4000, 16'h4000, 16'h0, 16'h0);
    send_req(REQ_STAGE, 7'd3, 4'd2, 4'd3, 16'hFFFF, 16'h8000, 16'h0, 16'h0);
    send_req(REQ_STAGE, 7'd4, 4'd3, 4'd0, 16'hC000, 16'h2000, 16'h0, 16'h0);
    send_req(REQ_PROPAGATE, 7'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    drain();

    for (int p = 0; p < 9; p++) begin
      tx_idle = (p < 3) ? 38 : (p < 6) ? 83 : 0;
      rx_idle = (p < 3) ? 83 : (p < 6) ? 38 : 0;
      write_reg(CFG_MODE_COUNT, {3'b000, mode_set[p]});
      write_reg(CFG_STAGE_COUNT, stage_set[p]);
      random_phase(40);
      drain();
    end

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
